/* rtl/line_rasterizer_macros.svh */
// Assertion macros for the line rasterizer.
`ifndef LINE_RASTERIZER_MACROS_SVH
`define LINE_RASTERIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only out of reset
`define LR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset too
`define LR_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LR_ASSERT(name, prop, msg)

`define LR_ASSERT_RST(name, prop, msg)

`endif

`endif

/* rtl/lr_pkg.sv */
package lr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int SW_BITS = 13;
  localparam logic [SW_BITS-1:0] SW_RESET = 13'd640;
  localparam int QUEUE_DEPTH = 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef enum logic [0:0] {
    ST_READY,
    ST_DIVIDE
  } back_state_t;

endpackage

/* rtl/lr_if.sv */
interface lr_item_if import lr_pkg::*; #(
  parameter int W = COORD_BITS_DEF
) ();
  logic         valid;
  logic         ready;
  logic         cmd;
  logic [W-1:0] x_first;
  logic [W-1:0] y_first;
  logic [W-1:0] x_second;
  logic [W-1:0] y_second;
  logic [31:0]  line_color;

  modport source (
    output valid, cmd, x_first, y_first, x_second, y_second, line_color,
    input  ready
  );
  modport sink (
    input  valid, cmd, x_first, y_first, x_second, y_second, line_color,
    output ready
  );
endinterface

interface lr_pixel_if import lr_pkg::*; #(
  parameter int W = COORD_BITS_DEF
) ();
  logic         valid;
  logic         ready;
  logic         pixel_valid;
  logic [W-1:0] pixel_x;
  logic [W-1:0] pixel_y;
  logic [31:0]  pixel_color;
  logic         last_pixel;

  modport source (
    output valid, pixel_valid, pixel_x, pixel_y, pixel_color, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_valid, pixel_x, pixel_y, pixel_color, last_pixel,
    output ready
  );
endinterface

interface lr_cfg_if import lr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SW_BITS-1:0] screen_width;

  modport source (output valid, screen_width, input ready);
  modport sink (input valid, screen_width, output ready);
endinterface

/* rtl/lr_front.sv */
module lr_front import lr_pkg::*; #(
  parameter int W     = COORD_BITS_DEF,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input logic      clk,
  input logic      rst,
  lr_item_if.sink  item,
  lr_item_if.source que
);

  localparam int ITEM_W = 4 * W + 33;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic [ITEM_W-1:0] entry [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;
  logic [ITEM_W-1:0] head;

  assign item.ready = (count != CNT_W'(DEPTH));
  assign que.valid  = (count != '0);
  assign push       = item.valid && item.ready;
  assign pop        = que.valid && que.ready;

  assign head           = entry[rd_ptr];
  assign que.cmd        = head[ITEM_W-1];
  assign que.x_first    = head[4*W+31 -: W];
  assign que.y_first    = head[3*W+31 -: W];
  assign que.x_second   = head[2*W+31 -: W];
  assign que.y_second   = head[W+31 -: W];
  assign que.line_color = head[31:0];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= {item.cmd, item.x_first, item.y_first, item.x_second,
                        item.y_second, item.line_color};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/lr_div.sv */
module lr_div import lr_pkg::*; #(
  parameter int W = COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dsr;
  logic [W:0]       shifted;
  logic [W:0]       diff;
  logic             fits;

  assign shifted   = {rem, quo[W-1]};
  assign diff      = shifted - {1'b0, dsr};
  assign fits      = (shifted >= {1'b0, dsr});
  assign quotient  = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[W-1:0] : shifted[W-1:0];
      quo <= {quo[W-2:0], fits};
    end
  end

endmodule

/* rtl/lr_back.sv */
module lr_back import lr_pkg::*; #(
  parameter int W = COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [SW_BITS-1:0] screen_width,
  lr_item_if.sink            que,
  lr_pixel_if.source         pixel
);

  localparam int CW = (W > SW_BITS) ? W : SW_BITS;

  back_state_t state;
  back_state_t state_next;

  logic                active;
  logic                vertical_mode;
  logic [W-1:0]        cur_x;
  logic [W-1:0]        end_x;
  logic [W-1:0]        base_y;
  logic [W-1:0]        slope_remainder;
  logic signed [W:0]   slope_quotient;
  logic [W-1:0]        slope_error;
  logic [W-1:0]        delta_x;
  logic [W-1:0]        limit_y;
  logic [W-1:0]        fill_steps;
  logic [W-1:0]        fill_count;
  logic [31:0]         held_color;
  logic                neg_dy;
  logic                line_ok;

  logic                out_valid;
  logic                out_pv;
  logic [W-1:0]        out_x;
  logic [W-1:0]        out_y;
  logic [31:0]         out_color;
  logic                out_last;

  logic                pop;
  logic                pop_load;
  logic                pop_step;
  logic                div_start;
  logic                div_done;
  logic [W-1:0]        div_quo;
  logic [W-1:0]        div_rem;

  logic                is_vert;
  logic                x_lt;
  logic [W-1:0]        lx;
  logic [W-1:0]        ly;
  logic [W-1:0]        rx;
  logic [W-1:0]        ry;
  logic [W-1:0]        dx;
  logic                dy_neg;
  logic [W-1:0]        ady;
  logic                lx_on;
  logic [W-1:0]        end_x_load;
  logic [SW_BITS-1:0]  sw_m1;

  logic                active_next;
  logic [W-1:0]        base_next;
  logic [W-1:0]        cur_next;
  logic [W-1:0]        fill_next;
  logic [W-1:0]        err_next;
  logic [W:0]          err_sum;
  logic                err_wrap;
  logic signed [W+1:0] nb;
  logic                fill_room;
  logic [W:0]          q_pos;

  lr_div #(.W(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (ady),
    .divisor   (dx),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // decode a load
  always_comb begin
    is_vert    = (que.x_first == que.x_second);
    x_lt       = (que.x_first < que.x_second);
    lx         = x_lt ? que.x_first : que.x_second;
    ly         = x_lt ? que.y_first : que.y_second;
    rx         = x_lt ? que.x_second : que.x_first;
    ry         = x_lt ? que.y_second : que.y_first;
    dx         = rx - lx;
    dy_neg     = (ry < ly);
    ady        = dy_neg ? (ly - ry) : (ry - ly);
    lx_on      = (CW'(lx) < CW'(screen_width));
    sw_m1      = screen_width - SW_BITS'(1);
    end_x_load = (CW'(rx) < CW'(screen_width)) ? rx : W'(sw_m1);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_READY: begin
        if (div_start) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_READY;
        end
      end
      default: state_next = ST_READY;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    case (state)
      ST_READY: pop = que.valid && ((que.cmd == CMD_LOAD) || !out_valid || pixel.ready);
      ST_DIVIDE: pop = 1'b0;
      default: pop = 1'b0;
    endcase
    pop_load  = pop && (que.cmd == CMD_LOAD);
    pop_step  = pop && (que.cmd == CMD_STEP);
    div_start = pop_load && !is_vert;
  end

  assign que.ready = pop;

  // walk one pixel
  always_comb begin
    active_next = active;
    base_next   = base_y;
    cur_next    = cur_x;
    fill_next   = fill_count;
    err_next    = slope_error;
    err_sum     = {1'b0, slope_error} + {1'b0, slope_remainder};
    err_wrap    = (err_sum >= {1'b0, delta_x});
    nb          = $signed({2'b00, base_y}) + $signed({slope_quotient[W], slope_quotient})
                  + $signed({{(W + 1){1'b0}}, err_wrap});
    fill_room   = (({1'b0, base_y} + {1'b0, fill_count} + (W + 1)'(1)) <= {1'b0, limit_y});
    if (vertical_mode) begin
      if (base_y >= limit_y) begin
        active_next = 1'b0;
      end else begin
        base_next = base_y + W'(1);
      end
    end else if ((fill_count < fill_steps) && fill_room) begin
      fill_next = fill_count + W'(1);
    end else if (cur_x >= end_x) begin
      active_next = 1'b0;
    end else begin
      cur_next  = cur_x + W'(1);
      fill_next = '0;
      err_next  = err_wrap ? W'(err_sum - {1'b0, delta_x}) : err_sum[W-1:0];
      base_next = nb[W+1] ? '0 : nb[W-1:0];
    end
  end

  assign q_pos = {1'b0, div_quo};

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_READY;
      active          <= 1'b0;
      vertical_mode   <= 1'b0;
      cur_x           <= '0;
      end_x           <= '0;
      base_y          <= '0;
      slope_remainder <= '0;
      slope_quotient  <= '0;
      slope_error     <= '0;
      delta_x         <= '0;
      limit_y         <= '0;
      fill_steps      <= '0;
      fill_count      <= '0;
      held_color      <= '0;
      neg_dy          <= 1'b0;
      line_ok         <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (pop_step) begin
        out_valid <= 1'b1;
      end else if (pixel.ready) begin
        out_valid <= 1'b0;
      end
      if (pop_load) begin
        held_color  <= que.line_color;
        limit_y     <= (que.y_first > que.y_second) ? que.y_first : que.y_second;
        fill_count  <= '0;
        slope_error <= '0;
        if (is_vert) begin
          vertical_mode <= 1'b1;
          cur_x         <= que.x_first;
          end_x         <= que.x_first;
          base_y        <= (que.y_first < que.y_second) ? que.y_first : que.y_second;
          active        <= 1'b1;
        end else begin
          vertical_mode <= 1'b0;
          delta_x       <= dx;
          cur_x         <= lx;
          base_y        <= ly;
          neg_dy        <= dy_neg;
          line_ok       <= lx_on;
          end_x         <= lx_on ? end_x_load : '0;
          active        <= 1'b0;
        end
      end else if (pop_step && active) begin
        active      <= active_next;
        base_y      <= base_next;
        cur_x       <= cur_next;
        fill_count  <= fill_next;
        slope_error <= err_next;
      end
      if (div_done) begin
        fill_steps <= div_quo;
        active     <= line_ok;
        if (!neg_dy) begin
          slope_quotient  <= $signed(q_pos);
          slope_remainder <= div_rem;
        end else if (div_rem == '0) begin
          slope_quotient  <= -$signed(q_pos);
          slope_remainder <= '0;
        end else begin
          slope_quotient  <= -$signed(q_pos) - $signed((W + 1)'(1));
          slope_remainder <= delta_x - div_rem;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_step) begin
      if (active) begin
        out_pv    <= 1'b1;
        out_x     <= cur_x;
        out_y     <= vertical_mode ? base_y : (base_y + fill_count);
        out_color <= held_color;
        out_last  <= !active_next;
      end else begin
        out_pv    <= 1'b0;
        out_x     <= '0;
        out_y     <= '0;
        out_color <= '0;
        out_last  <= 1'b0;
      end
    end
  end

  assign pixel.valid       = out_valid;
  assign pixel.pixel_valid = out_pv;
  assign pixel.pixel_x     = out_x;
  assign pixel.pixel_y     = out_y;
  assign pixel.pixel_color = out_color;
  assign pixel.last_pixel  = out_last;

endmodule

/* rtl/line_rasterizer.sv */
// Channel  Role    Word
// item     sink    cmd, x_first, y_first, x_second, y_second, line_color
// pixel    source  pixel_valid, pixel_x, pixel_y, pixel_color, last_pixel
// cfg      sink    screen_width (always ready)
//
// One pixel word per step word, one per cycle unless pixel or the divider stalls.
// A sloped load runs the radix-2 divider; no words are taken until it is done.
// Vertical loads skip it. A two-word queue decouples item from the back end.
// Synchronous reset empties the queue, drops the line, sets screen_width to 640.
// A stalled pixel word holds step words; the queue takes item words until full.
`include "line_rasterizer_macros.svh"

module line_rasterizer import lr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  lr_item_if.sink    item,
  lr_pixel_if.source pixel,
  lr_cfg_if.sink     cfg
);

  logic [SW_BITS-1:0] screen_width;

  lr_item_if #(.W(COORD_BITS)) que ();

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= SW_RESET;
    end else if (cfg.valid) begin
      screen_width <= cfg.screen_width;
    end
  end

  lr_front #(.W(COORD_BITS), .DEPTH(QUEUE_DEPTH)) u_front (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .que  (que)
  );

  lr_back #(.W(COORD_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .screen_width (screen_width),
    .que          (que),
    .pixel        (pixel)
  );

  `LR_ASSERT_RST(a_reset_quiet, rst |=> !pixel.valid, "pixel word present after reset")
  `LR_ASSERT(a_idle_zero, (pixel.valid && !pixel.pixel_valid) |-> (pixel.pixel_x == '0 && pixel.pixel_y == '0 && pixel.pixel_color == '0 && !pixel.last_pixel), "idle step word not zero")
  `LR_ASSERT(a_last_valid, (pixel.valid && pixel.last_pixel) |-> pixel.pixel_valid, "last pixel without a pixel")

endmodule
